// ----- rtl/lsps_pkg.sv -----
// package for the leaper shortest path search block
// holds payload structs, register indexes and sequencer state type; no dependencies
package lsps_pkg;

   typedef struct packed {
      logic [3:0] start_row;
      logic [3:0] start_col;
      logic [3:0] target_row;
      logic [3:0] target_col;
   } req_type;

   typedef struct packed {
      logic       reachable;
      logic [5:0] move_count;
      logic [3:0] cell_row;
      logic [3:0] cell_col;
      logic       last_cell;
   } rsp_type;

   localparam logic [1:0] REG_ROWS = 2'd0;
   localparam logic [1:0] REG_COLS = 2'd1;
   localparam logic [1:0] REG_P    = 2'd2;
   localparam logic [1:0] REG_Q    = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DEQ,
      ST_MOVE,
      ST_TRACE,
      ST_EMIT,
      ST_FAIL,
      ST_WAIT
   } state_type;

endpackage

// ----- rtl/lsps_move_unit.sv -----
// shared move unit: applies one leap of the leaper to a cell and checks the board edge
// depends on lsps_pkg
module lsps_move_unit #(
   parameter int RowBits = 3,
   parameter int ColBits = 3
) (
   input  logic [RowBits-1:0] cur_row,
   input  logic [ColBits-1:0] cur_col,
   input  logic [2:0]         move_idx,
   input  logic [2:0]         step_p,
   input  logic [2:0]         step_q,
   input  logic [3:0]         rows,
   input  logic [3:0]         cols,
   output logic [RowBits-1:0] new_row,
   output logic [ColBits-1:0] new_col,
   output logic               on_board
);
   import lsps_pkg::*;

   logic [2:0] dr_mag;
   logic [2:0] dc_mag;
   logic       dr_neg;
   logic       dc_neg;
   logic signed [5:0] nr;
   logic signed [5:0] nc;

   always_comb begin
      dr_mag = move_idx[2] ? step_q : step_p;
      dc_mag = move_idx[2] ? step_p : step_q;
      dr_neg = move_idx[1];
      dc_neg = move_idx[0];
      nr = dr_neg ? $signed(6'(cur_row)) - $signed(6'(dr_mag))
                  : $signed(6'(cur_row)) + $signed(6'(dr_mag));
      nc = dc_neg ? $signed(6'(cur_col)) - $signed(6'(dc_mag))
                  : $signed(6'(cur_col)) + $signed(6'(dc_mag));
      on_board = (nr >= 0) && (nr < $signed(6'(rows))) &&
                 (nc >= 0) && (nc < $signed(6'(cols)));
      new_row = nr[RowBits-1:0];
      new_col = nc[ColBits-1:0];
   end

endmodule

// ----- rtl/leaper_shortest_path_search.sv -----
// leaper shortest path search: one query walks the board by breadth-first search and
// replies with the path cells, or with one unreachable result. after the accept a query
// passes a check state, then per dequeued cell a dequeue state and the move state, in
// which one shared move unit tries up to 8 leaps, one a cycle; then the trace state once per path
// cell and an emit per result, which result stalls hold. one query at a time, the next is taken
// in the cycle after the last result leaves. synchronous active-high reset sets the registers to 8, 8, 1, 2 and idles.
module leaper_shortest_path_search #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lsps_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lsps_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [3:0]        csr_data
);
   import lsps_pkg::*;

   localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CB = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AB = RB + CB;
   localparam int CELLS = 1 << AB;
   localparam int NB = AB + 1;

   logic [3:0] rows_reg_ff, cols_reg_ff;
   logic [2:0] p_ff, q_ff;
   logic [3:0] rows_c, cols_c;

   state_type state_ff, state_in;
   req_type   req_ff;

   // visited flags, cleared while idle
   logic [CELLS-1:0] vis_ff;
   // scratch memories: predecessor, queue, path stack
   logic [AB-1:0] pred_mem [CELLS];
   logic [AB-1:0] queue_mem[CELLS];
   logic [AB-1:0] stack_mem[CELLS];

   logic [NB-1:0] head_ff, tail_ff, sp_ff;
   logic [AB-1:0] cur_ff, start_ff, target_ff, trace_ff;
   logic [2:0]    move_ff;
   logic [5:0]    moves_ff;
   rsp_type       rsp_ff;
   logic          rsp_valid_ff;

   logic [RB-1:0] new_row;
   logic [CB-1:0] new_col;
   logic          on_board;
   logic [AB-1:0] nx;
   logic          in_range;
   logic          same_cell;

   always_comb begin
      rows_c = (rows_reg_ff == 4'd0) ? 4'd1 :
               (rows_reg_ff > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_reg_ff;
      cols_c = (cols_reg_ff == 4'd0) ? 4'd1 :
               (cols_reg_ff > 4'(MAX_COLS)) ? 4'(MAX_COLS) : cols_reg_ff;
   end

   lsps_move_unit #(.RowBits(RB), .ColBits(CB)) u_move (
      .cur_row (cur_ff[AB-1:CB]),
      .cur_col (cur_ff[CB-1:0]),
      .move_idx(move_ff),
      .step_p  (p_ff),
      .step_q  (q_ff),
      .rows    (rows_c),
      .cols    (cols_c),
      .new_row (new_row),
      .new_col (new_col),
      .on_board(on_board)
   );

   assign nx = {new_row, new_col};
   assign in_range = (req_ff.start_row  >= 4'd1) && (req_ff.start_row  <= rows_c) &&
                     (req_ff.start_col  >= 4'd1) && (req_ff.start_col  <= cols_c) &&
                     (req_ff.target_row >= 4'd1) && (req_ff.target_row <= rows_c) &&
                     (req_ff.target_col >= 4'd1) && (req_ff.target_col <= cols_c);
   assign same_cell = (req_ff.start_row == req_ff.target_row) &&
                      (req_ff.start_col == req_ff.target_col);

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic discover;
   assign discover = on_board && !vis_ff[nx];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CHECK;
         // start equals target needs no search, its path is the start cell alone
         ST_CHECK: state_in = !in_range ? ST_FAIL : same_cell ? ST_TRACE : ST_DEQ;
         ST_DEQ:   state_in = (head_ff == tail_ff) ? ST_FAIL : ST_MOVE;
         ST_MOVE: begin
            if (discover && nx == target_ff) state_in = ST_TRACE;
            else if (move_ff == 3'd7) state_in = ST_DEQ;
         end
         ST_TRACE: if (trace_ff == start_ff) state_in = ST_EMIT;
         ST_EMIT:  if ((!rsp_valid_ff || rsp_ready) && sp_ff == NB'(1)) state_in = ST_WAIT;
         ST_FAIL:  if (!rsp_valid_ff || rsp_ready) state_in = ST_WAIT;
         ST_WAIT:  if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_reg_ff  <= 4'd8;
         cols_reg_ff  <= 4'd8;
         p_ff         <= 3'd1;
         q_ff         <= 3'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROWS: rows_reg_ff <= csr_data;
               REG_COLS: cols_reg_ff <= csr_data;
               REG_P:    p_ff <= csr_data[2:0];
               REG_Q:    q_ff <= csr_data[2:0];
               default:  ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if ((state_ff == ST_FAIL) && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         if ((state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            req_ff <= req_data;
            vis_ff <= '0;
         end
         ST_CHECK: begin
            start_ff  <= {RB'(req_ff.start_row - 4'd1), CB'(req_ff.start_col - 4'd1)};
            target_ff <= {RB'(req_ff.target_row - 4'd1), CB'(req_ff.target_col - 4'd1)};
            vis_ff[{RB'(req_ff.start_row - 4'd1), CB'(req_ff.start_col - 4'd1)}] <= 1'b1;
            queue_mem[0] <= {RB'(req_ff.start_row - 4'd1), CB'(req_ff.start_col - 4'd1)};
            head_ff <= '0;
            tail_ff <= NB'(1);
            trace_ff <= {RB'(req_ff.target_row - 4'd1), CB'(req_ff.target_col - 4'd1)};
            sp_ff <= '0;
         end
         ST_DEQ: begin
            cur_ff      <= queue_mem[head_ff[AB-1:0]];
            head_ff     <= head_ff + NB'(1);
            move_ff     <= '0;
         end
         ST_MOVE: begin
            move_ff <= move_ff + 3'd1;
            if (discover) begin
               vis_ff[nx]   <= 1'b1;
               pred_mem[nx] <= cur_ff;
               if (tail_ff < NB'(CELLS)) begin
                  queue_mem[tail_ff[AB-1:0]] <= nx;
                  tail_ff <= tail_ff + NB'(1);
               end
            end
         end
         ST_TRACE: begin
            stack_mem[sp_ff[AB-1:0]] <= trace_ff;
            sp_ff    <= sp_ff + NB'(1);
            trace_ff <= pred_mem[trace_ff];
            moves_ff <= 6'(sp_ff);
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_ff.reachable  <= 1'b1;
               rsp_ff.move_count <= moves_ff;
               rsp_ff.cell_row   <= 4'(stack_mem[sp_ff[AB-1:0] - AB'(1)][AB-1:CB]) + 4'd1;
               rsp_ff.cell_col   <= 4'(stack_mem[sp_ff[AB-1:0] - AB'(1)][CB-1:0]) + 4'd1;
               rsp_ff.last_cell  <= (sp_ff == NB'(1));
               sp_ff <= sp_ff - NB'(1);
            end
         end
         ST_FAIL: begin
            if (!rsp_valid_ff || rsp_ready) rsp_ff <= '{default: '0, last_cell: 1'b1};
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("ready while busy");
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reachable |-> rsp_data.last_cell)
      else $error("unreachable result not last");
`endif

endmodule
